// ===== design/pncf_pkg.sv =====
// package for the prefix next-character filter
// holds the action and status codes, the item structs and the upcase helper
// no dependencies
package pncf_pkg;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned SET_W = 2 ** CHAR_W;

  localparam logic [CHAR_W-1:0] LOWER_A = 7'd97;
  localparam logic [CHAR_W-1:0] LOWER_Z = 7'd122;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;

  typedef enum logic [2:0] {
    ACT_CLEAR      = 3'd0,
    ACT_PREFIX     = 3'd1,
    ACT_LINE_CHAR  = 3'd2,
    ACT_END_LINE   = 3'd3,
    ACT_REPORT     = 3'd4,
    ACT_READ_MATCH = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_NOT_FOUND  = 3'd0,
    ST_FOUND      = 3'd1,
    ST_ENABLE     = 3'd2,
    ST_NO_LINES   = 3'd3,
    ST_LINE_LONG  = 3'd4,
    ST_PREFIX_LONG = 3'd5
  } status_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_MATCH_CHAR = 1'b1
  } reply_kind_e;

  typedef struct packed {
    action_e             action;
    logic [CHAR_W-1:0]   char_code;
    logic [CHAR_W-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    reply_kind_e         reply_kind;
    status_e             status;
    logic [63:0]         enabled_low;
    logic [63:0]         enabled_high;
    logic [CHAR_W-1:0]   match_length;
    logic [CHAR_W-1:0]   match_char;
  } out_item_t;

  function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      v = c - CASE_OFFSET;
    end
    return v;
  endfunction

endpackage

// ===== design/prefix_next_char_filter.sv =====
// top level of the prefix next-character filter
// depends on pncf_pkg and pncf_ram
//
// usage: items arrive on in_item_i under in_valid_i / in_ready_o, results leave
// on out_item_o under out_valid_o / out_ready_i. an item is taken when valid
// and ready are both high. report and read-match-char items give one result,
// all other items give none. clear restores the empty state in one item.
// the block takes one item every cycle while in_ready_o is high. an item passes an
// input stage (prefix ram read), a judge stage (line ram access) and the output
// register, in that order.
// the output register parts the two sides: items that give no result keep
// flowing while a result waits. in_ready_o drops only when a result waiting in
// stage two meets a full output register that the receiver is stalling.
// reset empties the pipeline and clears all counters, flags and the
// next-character set; the prefix and line rams keep undefined contents until
// written, and no clearing pass is needed.
module prefix_next_char_filter
  import pncf_pkg::*;
#(
  parameter int unsigned MAX_LEN = 127
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output out_item_t out_item_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned PAW = $clog2(MAX_LEN);
  localparam int unsigned LAW = $clog2(2 * MAX_LEN);
  localparam logic [LW-1:0]  MAX_LEN_L = LW'(MAX_LEN);
  localparam logic [LAW-1:0] BANK_OFS  = LAW'(MAX_LEN);

  // handshake
  logic accept;
  logic advance;
  logic stall;

  // input stage state
  logic [LW-1:0] pl_q, pl_d;
  logic          pov_q, pov_d;
  logic [LW-1:0] ll_q, ll_d;
  logic          lov_q, lov_d;
  logic          any_q, any_d;
  logic [CHAR_W-1:0] c_up;

  // prefix ram
  logic             p_we;
  logic [PAW-1:0]   p_waddr;
  logic             p_re;
  logic [PAW-1:0]   p_raddr;
  logic [CHAR_W-1:0] p_rdata;

  // stage one
  logic              s1_valid_q, s1_valid_d;
  action_e           s1_action_q, s1_action_d;
  logic [CHAR_W-1:0] s1_char_q, s1_char_d;
  logic [CHAR_W-1:0] s1_idx_q, s1_idx_d;
  logic [LW-1:0]     s1_ll_q, s1_ll_d;
  logic [LW-1:0]     s1_pl_q, s1_pl_d;
  logic              s1_pov_q, s1_pov_d;
  logic              s1_lov_q, s1_lov_d;
  logic              s1_any_q, s1_any_d;

  // judge stage state
  logic              still_q, still_d;
  logic [CHAR_W-1:0] capt_q, capt_d;
  logic [SET_W-1:0]  enabled_q, enabled_d;
  logic [1:0]        count_q, count_d;
  logic [LW-1:0]     saved_q, saved_d;
  logic              bank_q, bank_d;
  logic              is_match;
  logic [CHAR_W-1:0] mark_char;

  // line ram
  logic              l_we;
  logic [LAW-1:0]    l_waddr;
  logic              l_re;
  logic [LAW-1:0]    l_raddr;
  logic [CHAR_W-1:0] l_rdata;
  logic              in_range;

  // stage two
  logic              s2_valid_q, s2_valid_d;
  reply_kind_e       s2_kind_q, s2_kind_d;
  status_e           s2_status_q, s2_status_d;
  logic [SET_W-1:0]  s2_set_q, s2_set_d;
  logic [LW-1:0]     s2_len_q, s2_len_d;
  logic              s2_range_q, s2_range_d;

  // output register
  logic      o_valid_q;
  out_item_t o_item_q;

  assign stall      = s2_valid_q && o_valid_q && !out_ready_i;
  assign advance    = !stall;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;
  assign c_up       = upcase(in_item_i.char_code);

  // input stage
  always_comb begin
    pl_d  = pl_q;
    pov_d = pov_q;
    ll_d  = ll_q;
    lov_d = lov_q;
    any_d = any_q;
    p_we    = 1'b0;
    p_waddr = pl_q[PAW-1:0];
    p_re    = 1'b0;
    p_raddr = ll_q[PAW-1:0];
    s1_valid_d  = 1'b0;
    s1_action_d = in_item_i.action;
    s1_char_d   = c_up;
    s1_idx_d    = in_item_i.read_index;
    s1_ll_d     = ll_q;
    s1_pl_d     = pl_q;
    s1_pov_d    = pov_q;
    s1_lov_d    = lov_q;
    s1_any_d    = any_q;
    if (accept) begin
      case (in_item_i.action)
        ACT_CLEAR: begin
          pl_d  = '0;
          pov_d = 1'b0;
          ll_d  = '0;
          lov_d = 1'b0;
          any_d = 1'b0;
          s1_valid_d = 1'b1;
        end
        ACT_PREFIX: begin
          if (pl_q < MAX_LEN_L) begin
            p_we = 1'b1;
            pl_d = pl_q + LW'(1);
          end else begin
            pov_d = 1'b1;
          end
        end
        ACT_LINE_CHAR: begin
          any_d = 1'b1;
          if (ll_q >= MAX_LEN_L) begin
            lov_d = 1'b1;
          end else begin
            p_re = ll_q < pl_q;
            ll_d = ll_q + LW'(1);
            s1_valid_d = 1'b1;
          end
        end
        ACT_END_LINE: begin
          any_d = 1'b1;
          ll_d  = '0;
          p_re  = pl_q != '0;
          p_raddr = PAW'(pl_q - LW'(1));
          s1_valid_d = 1'b1;
        end
        ACT_REPORT: begin
          s1_valid_d = 1'b1;
        end
        ACT_READ_MATCH: begin
          s1_valid_d = 1'b1;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end
  end

  pncf_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_LEN)
  ) u_prefix_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(c_up),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  // judge stage
  always_comb begin
    still_d   = still_q;
    capt_d    = capt_q;
    enabled_d = enabled_q;
    count_d   = count_q;
    saved_d   = saved_q;
    bank_d    = bank_q;
    mark_char = capt_q;
    l_we    = 1'b0;
    l_waddr = (bank_q ? '0 : BANK_OFS) + LAW'(s1_ll_q);
    in_range = s1_idx_q < CHAR_W'(saved_q);
    l_re    = 1'b0;
    l_raddr = (bank_q ? BANK_OFS : '0) + LAW'(s1_idx_q);
    s2_valid_d  = 1'b0;
    s2_kind_d   = KIND_REPORT;
    s2_status_d = ST_NOT_FOUND;
    s2_set_d    = '0;
    s2_len_d    = saved_q;
    s2_range_d  = 1'b0;
    is_match = still_q && s1_ll_q >= s1_pl_q && !(s1_ll_q == '0 && s1_pl_q == '0);
    if (s1_ll_q == s1_pl_q) begin
      mark_char = p_rdata;
    end
    if (advance && s1_valid_q) begin
      case (s1_action_q)
        ACT_CLEAR: begin
          still_d   = 1'b1;
          capt_d    = '0;
          enabled_d = '0;
          count_d   = '0;
          saved_d   = '0;
          bank_d    = 1'b0;
        end
        ACT_LINE_CHAR: begin
          if (s1_ll_q < s1_pl_q) begin
            if (p_rdata != s1_char_q) begin
              still_d = 1'b0;
            end
          end else if (s1_ll_q == s1_pl_q) begin
            capt_d = s1_char_q;
          end
          l_we = 1'b1;
        end
        ACT_END_LINE: begin
          if (is_match) begin
            enabled_d = enabled_q | (SET_W'(1) << mark_char);
            if (count_q != 2'd2) begin
              count_d = count_q + 2'd1;
            end
            saved_d = s1_ll_q;
            bank_d  = !bank_q;
          end
          still_d = 1'b1;
          capt_d  = '0;
        end
        ACT_REPORT: begin
          s2_valid_d = 1'b1;
          if (s1_pov_q) begin
            s2_status_d = ST_PREFIX_LONG;
          end else if (s1_lov_q) begin
            s2_status_d = ST_LINE_LONG;
          end else if (!s1_any_q) begin
            s2_status_d = ST_NO_LINES;
          end else begin
            s2_status_d = status_e'({1'b0, count_q});
          end
          s2_set_d = enabled_q;
        end
        ACT_READ_MATCH: begin
          s2_valid_d = 1'b1;
          s2_kind_d  = KIND_MATCH_CHAR;
          s2_range_d = in_range;
          l_re       = in_range;
        end
        default: begin
          s2_valid_d = 1'b0;
        end
      endcase
    end
  end

  pncf_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(2 * MAX_LEN)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(s1_char_q),
    .re_i   (l_re),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q       <= '0;
      pov_q      <= 1'b0;
      ll_q       <= '0;
      lov_q      <= 1'b0;
      any_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      still_q    <= 1'b1;
      capt_q     <= '0;
      enabled_q  <= '0;
      count_q    <= '0;
      saved_q    <= '0;
      bank_q     <= 1'b0;
      s2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      pl_q      <= pl_d;
      pov_q     <= pov_d;
      ll_q      <= ll_d;
      lov_q     <= lov_d;
      any_q     <= any_d;
      still_q   <= still_d;
      capt_q    <= capt_d;
      enabled_q <= enabled_d;
      count_q   <= count_d;
      saved_q   <= saved_d;
      bank_q    <= bank_d;
      if (advance) begin
        s1_valid_q <= s1_valid_d;
        s2_valid_q <= s2_valid_d;
      end
      if (advance && s2_valid_q) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_action_q <= s1_action_d;
      s1_char_q   <= s1_char_d;
      s1_idx_q    <= s1_idx_d;
      s1_ll_q     <= s1_ll_d;
      s1_pl_q     <= s1_pl_d;
      s1_pov_q    <= s1_pov_d;
      s1_lov_q    <= s1_lov_d;
      s1_any_q    <= s1_any_d;
      s2_kind_q   <= s2_kind_d;
      s2_status_q <= s2_status_d;
      s2_set_q    <= s2_set_d;
      s2_len_q    <= s2_len_d;
      s2_range_q  <= s2_range_d;
    end
    if (advance && s2_valid_q) begin
      o_item_q.reply_kind   <= s2_kind_q;
      o_item_q.status       <= s2_status_q;
      o_item_q.enabled_low  <= s2_set_q[63:0];
      o_item_q.enabled_high <= s2_set_q[127:64];
      o_item_q.match_length <= CHAR_W'(s2_len_q);
      o_item_q.match_char   <= s2_range_q ? l_rdata : '0;
    end
  end

  assign out_item_o  = o_item_q;
  assign out_valid_o = o_valid_q;

endmodule

// ===== design/pncf_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module pncf_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 127
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/prefix_next_char_filter_test.sv =====
`timescale 1ns / 100ps
// testbench for prefix_next_char_filter: drives prefix, line, report and read items
// and checks every result against a predictor kept in a small scoreboard class
// depends on pncf_pkg and the design files only

package pncf_test_pkg;
  import pncf_pkg::*;

  localparam int LINE_MAX = 127;

  class reply_board;
    logic [CHAR_W-1:0] pfx_chars [LINE_MAX];
    logic [CHAR_W-1:0] line_bank [2][LINE_MAX];
    int                pfx_len;
    bit                pfx_over;
    bit                bank_sel;
    int                cur_len;
    bit                still_ok;
    logic [CHAR_W-1:0] follow_char;
    bit                line_over;
    logic [SET_W-1:0]  next_set;
    int                hits;
    int                kept_len;
    bit                seen_line;
    out_item_t         awaited [$];
    int                errors;
    int                checked;
    int                status_count [8];

    function new();
      wipe();
      errors = 0;
      checked = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void wipe();
      pfx_len = 0;
      pfx_over = 0;
      bank_sel = 0;
      cur_len = 0;
      still_ok = 1;
      follow_char = '0;
      line_over = 0;
      next_set = '0;
      hits = 0;
      kept_len = 0;
      seen_line = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("error: %s", msg);
    endfunction

    // advance the predicted state by one accepted item
    function void take_item(in_item_t it);
      logic [CHAR_W-1:0] c;
      out_item_t         exp;
      c = it.char_code;
      if (c >= 7'd97 && c <= 7'd122) c = c - 7'd32;
      exp = '0;
      case (it.action)
        ACT_CLEAR: wipe();
        ACT_PREFIX: begin
          if (pfx_len < LINE_MAX) begin
            pfx_chars[pfx_len] = c;
            pfx_len++;
          end else begin
            pfx_over = 1;
          end
        end
        ACT_LINE_CHAR: begin
          seen_line = 1;
          if (cur_len >= LINE_MAX) begin
            line_over = 1;
          end else begin
            if (cur_len < pfx_len) begin
              if (pfx_chars[cur_len] != c) still_ok = 0;
            end else if (cur_len == pfx_len) begin
              follow_char = c;
            end
            line_bank[bank_sel ^ 1'b1][cur_len] = c;
            cur_len++;
          end
        end
        ACT_END_LINE: begin
          seen_line = 1;
          // empty line under empty prefix is not a match
          if (still_ok && cur_len >= pfx_len && !(cur_len == 0 && pfx_len == 0)) begin
            if (cur_len == pfx_len) next_set[pfx_chars[pfx_len-1]] = 1'b1;
            else next_set[follow_char] = 1'b1;
            if (hits < 2) hits++;
            kept_len = cur_len;
            bank_sel = bank_sel ^ 1'b1;
          end
          cur_len = 0;
          still_ok = 1;
          follow_char = '0;
        end
        ACT_REPORT: begin
          exp.reply_kind = KIND_REPORT;
          if (pfx_over) exp.status = ST_PREFIX_LONG;
          else if (line_over) exp.status = ST_LINE_LONG;
          else if (!seen_line) exp.status = ST_NO_LINES;
          else if (hits == 0) exp.status = ST_NOT_FOUND;
          else if (hits == 1) exp.status = ST_FOUND;
          else exp.status = ST_ENABLE;
          exp.enabled_low = next_set[63:0];
          exp.enabled_high = next_set[127:64];
          exp.match_length = kept_len[CHAR_W-1:0];
          status_count[exp.status]++;
          awaited.push_back(exp);
        end
        ACT_READ_MATCH: begin
          exp.reply_kind = KIND_MATCH_CHAR;
          exp.status = ST_NOT_FOUND;
          exp.match_length = kept_len[CHAR_W-1:0];
          if (it.read_index < kept_len) exp.match_char = line_bank[bank_sel][it.read_index];
          awaited.push_back(exp);
        end
        default: ;
      endcase
    endfunction

    function void match_reply(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        flag($sformatf("result with nothing awaited: %p", got));
      end else begin
        exp = awaited.pop_front();
        checked++;
        if (got !== exp) begin
          flag($sformatf("expected kind %0d status %0d low %h high %h len %0d char %0d",
                         exp.reply_kind, exp.status, exp.enabled_low, exp.enabled_high,
                         exp.match_length, exp.match_char));
          if (errors <= 10)
            $display("       got kind %0d status %0d low %h high %h len %0d char %0d",
                     got.reply_kind, got.status, got.enabled_low, got.enabled_high,
                     got.match_length, got.match_char);
        end
      end
    endfunction

    function void finish_check();
      if (awaited.size() != 0) flag($sformatf("%0d results never arrived", awaited.size()));
    endfunction
  endclass

endpackage

module prefix_next_char_filter_test;
  import pncf_pkg::*;
  import pncf_test_pkg::*;

  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 900000;

  logic      clk_i;
  logic      rst_ni;
  in_item_t  in_item_i;
  logic      in_valid_i;
  logic      in_ready_o;
  out_item_t out_item_o;
  logic      out_valid_o;
  logic      out_ready_i;

  reply_board board = new();
  int         cycles = 0;
  int         real_items = 0;
  int         ignored_items = 0;
  int         quiet_left = 0;
  int         drains = 0;
  string      alpha_set = "ABCabc";

  prefix_next_char_filter #(
    .MAX_LEN(LINE_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_item_o (out_item_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.match_reply(out_item_o);
  end

  // receiver: bursts of ready with short stalls, now and then a long one
  initial begin
    int hi;
    int lo;
    int mode;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 19);
      hi = (mode == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      lo = (mode < 3) ? $urandom_range(10, 50) : $urandom_range(0, 3);
      repeat (hi) begin
        @(negedge clk_i);
        out_ready_i = 1'b1;
      end
      repeat (lo) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) quiet_left = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    byte b;
    if ($urandom_range(0, 99) < 70) begin
      b = alpha_set[$urandom_range(0, 5)];
      return b[CHAR_W-1:0];
    end
    return CHAR_W'($urandom_range(0, 127));
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_item_i = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    board.take_item(it);
    if (it.action <= ACT_READ_MATCH) real_items++;
    else ignored_items++;
  endtask

  task automatic put(logic [2:0] act, logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] ix);
    in_item_t it;
    it.action = action_e'(act);
    it.char_code = ch;
    it.read_index = ix;
    send_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    drains++;
  endtask

  task automatic run_session();
    logic [CHAR_W-1:0] pfx [$];
    logic [CHAR_W-1:0] body [$];
    logic [CHAR_W-1:0] ch;
    int                plen;
    int                kind;
    int                slen;
    int                cut;
    if ($urandom_range(0, 4) != 0) put(ACT_CLEAR, pick_char(), CHAR_W'($urandom));
    case ($urandom_range(0, 24))
      0: plen = 0;
      1, 2, 3: plen = $urandom_range(4, 8);
      4: plen = $urandom_range(124, 131);
      default: plen = $urandom_range(1, 3);
    endcase
    repeat (plen) begin
      ch = pick_char();
      pfx.push_back(ch);
      put(ACT_PREFIX, ch, CHAR_W'($urandom));
    end
    repeat ($urandom_range(0, 5)) begin
      body.delete();
      kind = $urandom_range(0, 19);
      slen = ($urandom_range(0, 24) == 0) ? $urandom_range(120, 132) : $urandom_range(0, 3);
      if (kind < 15) begin
        foreach (pfx[i]) begin
          ch = pfx[i];
          // random case change keeps the line matching
          if ($urandom_range(0, 1)) begin
            if (ch >= 7'd65 && ch <= 7'd90) ch = ch + 7'd32;
            else if (ch >= 7'd97 && ch <= 7'd122) ch = ch - 7'd32;
          end
          body.push_back(ch);
        end
        if (kind >= 12 && body.size() > 0) body[$urandom_range(0, body.size() - 1)] = pick_char();
        repeat (slen) body.push_back(pick_char());
      end else if (kind < 18) begin
        repeat ($urandom_range(0, 6)) body.push_back(pick_char());
      end else if (kind == 19 && pfx.size() > 1) begin
        cut = $urandom_range(1, pfx.size() - 1);
        for (int i = 0; i < cut; i++) body.push_back(pfx[i]);
      end
      foreach (body[i]) begin
        if ($urandom_range(0, 99) < 4) begin
          case ($urandom_range(0, 3))
            0: put(ACT_REPORT, pick_char(), CHAR_W'($urandom));
            1: put(ACT_READ_MATCH, pick_char(), CHAR_W'($urandom));
            2: put(ACT_PREFIX, pick_char(), CHAR_W'($urandom));
            default: put($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B,
                         CHAR_W'($urandom), CHAR_W'($urandom));
          endcase
        end
        put(ACT_LINE_CHAR, body[i], CHAR_W'($urandom));
      end
      if ($urandom_range(0, 99) < 92) put(ACT_END_LINE, pick_char(), CHAR_W'($urandom));
    end
    put(ACT_REPORT, pick_char(), CHAR_W'($urandom));
    repeat ($urandom_range(0, 3)) begin
      if (board.kept_len > 0 && $urandom_range(0, 3) != 0)
        put(ACT_READ_MATCH, pick_char(), CHAR_W'($urandom_range(0, board.kept_len - 1)));
      else
        put(ACT_READ_MATCH, pick_char(), CHAR_W'($urandom_range(0, 127)));
    end
    if ($urandom_range(0, 7) == 0) drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // no lines yet, read with nothing stored, empty line under empty prefix
    put(ACT_REPORT, 7'd0, 7'd0);
    put(ACT_READ_MATCH, 7'd0, 7'd0);
    put(ACT_END_LINE, 7'd0, 7'd0);
    put(ACT_REPORT, 7'd0, 7'd0);
    // prefix "az" in lower case, lines "Az<del>", "aZ" (exact) and "<nul>"
    put(ACT_PREFIX, 7'd97, 7'd0);
    put(ACT_PREFIX, 7'd122, 7'd127);
    put(ACT_LINE_CHAR, 7'd65, 7'd0);
    put(ACT_LINE_CHAR, 7'd122, 7'd0);
    put(ACT_LINE_CHAR, 7'd127, 7'd0);
    put(ACT_END_LINE, 7'd0, 7'd0);
    put(ACT_LINE_CHAR, 7'd97, 7'd0);
    put(ACT_LINE_CHAR, 7'd90, 7'd0);
    put(ACT_END_LINE, 7'd0, 7'd0);
    put(ACT_LINE_CHAR, 7'd0, 7'd0);
    put(ACT_END_LINE, 7'd127, 7'd127);
    put(ACT_REPORT, 7'd0, 7'd0);
    put(ACT_READ_MATCH, 7'd0, 7'd1);
    put(ACT_READ_MATCH, 7'd127, 7'd127);
    put(ACT_SPARE_A, 7'd127, 7'd127);
    put(ACT_SPARE_B, 7'd127, 7'd127);
    // prefix grows while a line is in progress
    put(ACT_CLEAR, 7'd127, 7'd127);
    put(ACT_LINE_CHAR, 7'd81, 7'd0);
    put(ACT_PREFIX, 7'd113, 7'd0);
    put(ACT_LINE_CHAR, 7'd82, 7'd0);
    put(ACT_END_LINE, 7'd0, 7'd0);
    put(ACT_REPORT, 7'd0, 7'd0);
    drain();

    while (real_items < ITEM_TARGET) run_session();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    board.finish_check();

    $display("covered %0d items (%0d with unused codes), %0d results checked, %0d drains",
             real_items, ignored_items, board.checked, drains);
    $display("reports: %0d enable, %0d found, %0d no lines, %0d line long, %0d prefix long",
             board.status_count[ST_ENABLE], board.status_count[ST_FOUND],
             board.status_count[ST_NO_LINES], board.status_count[ST_LINE_LONG],
             board.status_count[ST_PREFIX_LONG]);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors", board.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
